[rtl/core/clm_pkg.sv]
package clm_pkg;

    // table geometry
    localparam int NUM_LOCKS   = 256;
    localparam int NUM_CLIENTS = 256;
    localparam int QUEUE_DEPTH = 8;
    localparam int LOCK_W      = $clog2(NUM_LOCKS);
    localparam int CLIENT_W    = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int WADDR_W     = LOCK_W + QPTR_W;

    // operation codes
    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // reply codes
    localparam logic [1:0] REPLY_OK     = 2'd0;
    localparam logic [1:0] REPLY_RETRY  = 2'd1;
    localparam logic [1:0] REPLY_RETIRE = 2'd2;

    // notification kinds
    localparam logic [1:0] NOTE_NONE   = 2'd0;
    localparam logic [1:0] NOTE_REVOKE = 2'd1;
    localparam logic [1:0] NOTE_RETRY  = 2'd2;

    // one lock table entry
    typedef struct packed {
        logic                held;
        logic [CLIENT_W-1:0] holder;
        logic [QPTR_W-1:0]   head;
        logic [QCNT_W-1:0]   count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one result word
    typedef struct packed {
        logic [1:0]          reply;
        logic [1:0]          kind;
        logic [CLIENT_W-1:0] target;
        logic                ovf;
    } t_result;

    // waiter queue write request
    typedef struct packed {
        logic              en;
        logic [QPTR_W-1:0] slot;
    } t_wq;

endpackage

[rtl/core/clm_ram.sv]
module clm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/clm_update.sv]
module clm_update (
    input  logic                         i_func,
    input  logic [clm_pkg::CLIENT_W-1:0] i_client,
    input  clm_pkg::t_entry              i_entry,
    input  logic [clm_pkg::CLIENT_W-1:0] i_next,
    output clm_pkg::t_entry              o_entry,
    output clm_pkg::t_result             o_res,
    output clm_pkg::t_wq                 o_wq,
    output logic                         o_pop
);
    import clm_pkg::*;

    logic is_holder;
    logic full;
    logic empty;

    assign is_holder = i_entry.held && (i_entry.holder == i_client);
    assign full      = (i_entry.count == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (i_entry.count == '0);

    // lock state transition and reply
    always_comb begin
        o_entry = i_entry;
        o_res   = '0;
        o_wq.en   = 1'b0;
        o_wq.slot = i_entry.head + i_entry.count[QPTR_W-1:0];
        o_pop   = 1'b0;
        o_res.reply = REPLY_OK;
        o_res.kind  = NOTE_NONE;
        unique case (i_func)
            FUNC_ACQUIRE: begin
                if (i_entry.held) begin
                    if (i_entry.holder != i_client) begin
                        o_res.reply = REPLY_RETRY;
                        if (full) begin
                            o_res.ovf = 1'b1;
                        end else begin
                            o_wq.en       = 1'b1;
                            o_entry.count = i_entry.count + QCNT_W'(1);
                            if (empty) begin
                                o_res.kind   = NOTE_REVOKE;
                                o_res.target = i_entry.holder;
                            end
                        end
                    end else if (!empty) begin
                        o_res.reply = REPLY_RETIRE;
                    end
                end else if (empty) begin
                    o_entry.held   = 1'b1;
                    o_entry.holder = i_client;
                end
            end
            FUNC_RELEASE: begin
                if (is_holder) begin
                    if (!empty) begin
                        // hand over to the head waiter
                        o_pop          = 1'b1;
                        o_entry.head   = i_entry.head + QPTR_W'(1);
                        o_entry.count  = i_entry.count - QCNT_W'(1);
                        o_entry.holder = i_next;
                        o_res.kind     = NOTE_RETRY;
                        o_res.target   = i_next;
                    end else begin
                        o_entry.held = 1'b0;
                    end
                end
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
    end

endmodule

[rtl/core/caching_lock_manager.sv]
// Lock table engine.
// Slave stream carries requests: tuser is the operation (acquire or
// release), tdata the lock index and client id. Master stream carries one
// result word per request: tuser is the notification kind, tdata the reply
// code, notification target and queue overflow flag.
// The result word is registered after its request is accepted: the lock
// table is read, then the decide state writes back and loads the result.
// When a release hands the lock to a waiter, the head waiter is first read
// from the queue memory and the write back happens in the pop state.
// One request is in flight at a time: the next is accepted once the
// previous one has been written back, even if its result still waits.
// The lock table and waiter queues sit in two single-port-write RAMs with
// a registered read.
// Reset clears the per-lock valid bits at once, so every lock reads as
// free with an empty queue; no clearing pass is needed.
// If the receiver stalls, the result is held in the output register and
// a following request waits in S_LOOK or S_POP until the register frees.
module caching_lock_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] lock_index, [15:8] client_id
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [1:0] reply_code, [9:2] notify_client,
                                       // [10] queue_overflow, [15:11] zero
    output logic [1:0]  m_axis_tuser   // notify_kind
);
    import clm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic                r_func;
    logic [LOCK_W-1:0]   r_lock;
    logic [CLIENT_W-1:0] r_client;
    logic [NUM_LOCKS-1:0] r_valid;
    logic                r_out_valid;
    t_result             r_out;

    logic                accept;
    logic                out_free;
    logic                commit;
    logic [ENTRY_W-1:0]  lt_rd_data;
    t_entry              cur_entry;
    t_entry              new_entry;
    t_result             res;
    t_wq                 wq;
    logic                pop;
    logic [CLIENT_W-1:0] next_waiter;
    logic                wq_rd_en;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // unwritten lock entries read as free with an empty queue
    assign cur_entry = r_valid[r_lock] ? t_entry'(lt_rd_data) : t_entry'('0);

    // commit once the output is free, after the waiter read if a pop needs it
    always_comb begin
        commit   = 1'b0;
        wq_rd_en = 1'b0;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (pop) begin
                    wq_rd_en = 1'b1;
                    n_state  = S_POP;
                end else if (out_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_valid[r_lock] <= 1'b1;
                r_out_valid     <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= s_axis_tuser;
            r_lock   <= s_axis_tdata[LOCK_W-1:0];
            r_client <= s_axis_tdata[15:8];
        end
        if (commit) begin
            r_out <= res;
        end
    end

    // lock table: held, holder, queue head and count
    clm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_LOCKS)
    ) u_lock_table (
        .i_clk     (i_clk),
        .i_wr_en   (commit),
        .i_wr_addr (r_lock),
        .i_wr_data (new_entry),
        .i_rd_en   (accept),
        .i_rd_addr (s_axis_tdata[LOCK_W-1:0]),
        .o_rd_data (lt_rd_data)
    );

    // waiter queues, one ring of QUEUE_DEPTH per lock
    clm_ram #(
        .WIDTH (CLIENT_W),
        .DEPTH (NUM_LOCKS * QUEUE_DEPTH)
    ) u_waiters (
        .i_clk     (i_clk),
        .i_wr_en   (commit && wq.en),
        .i_wr_addr ({r_lock, wq.slot}),
        .i_wr_data (r_client),
        .i_rd_en   (wq_rd_en),
        .i_rd_addr ({r_lock, cur_entry.head}),
        .o_rd_data (next_waiter)
    );

    // decision logic
    clm_update u_update (
        .i_func   (r_func),
        .i_client (r_client),
        .i_entry  (cur_entry),
        .i_next   (next_waiter),
        .o_entry  (new_entry),
        .o_res    (res),
        .o_wq     (wq),
        .o_pop    (pop)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.ovf, r_out.target, r_out.reply};
    assign m_axis_tuser  = r_out.kind;

endmodule

[verif/tb_caching_lock_manager.sv]
`timescale 1ns / 100ps

module tb_caching_lock_manager;
    import clm_pkg::*;

    localparam int DIRECTED_ROWS = 21;
    localparam int RANDOM_ITEMS  = 930;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    // one request with an optional hand-written answer
    typedef struct packed {
        logic                fn;
        logic [LOCK_W-1:0]   lk;
        logic [CLIENT_W-1:0] cl;
        logic                typed;
        t_result             res;
    } t_req_row;

    // opening sequence: fill lock 0 to overflow, hand it over, then a plain
    // grant/free cycle on the top lock
    localparam t_req_row PLAN [0:DIRECTED_ROWS-1] = '{
        '{FUNC_ACQUIRE, 8'd0,   8'd0,   1'b1, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd0,   1'b1, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd255, 1'b1, '{REPLY_RETRY,  NOTE_REVOKE, 8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd0,   1'b1, '{REPLY_RETIRE, NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd1,   1'b1, '{REPLY_RETRY,  NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd2,   1'b1, '{REPLY_RETRY,  NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd3,   1'b1, '{REPLY_RETRY,  NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd4,   1'b1, '{REPLY_RETRY,  NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd5,   1'b1, '{REPLY_RETRY,  NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd6,   1'b1, '{REPLY_RETRY,  NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd7,   1'b1, '{REPLY_RETRY,  NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd200, 1'b1, '{REPLY_RETRY,  NOTE_NONE,   8'd0,   1'b1}},
        '{FUNC_RELEASE, 8'd0,   8'd9,   1'b1, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_RELEASE, 8'd0,   8'd0,   1'b1, '{REPLY_OK,     NOTE_RETRY,  8'd255, 1'b0}},
        '{FUNC_RELEASE, 8'd0,   8'd255, 1'b0, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd0,   8'd1,   1'b0, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_RELEASE, 8'd255, 8'd255, 1'b1, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd255, 8'd128, 1'b1, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_RELEASE, 8'd255, 8'd128, 1'b1, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_ACQUIRE, 8'd255, 8'd127, 1'b1, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}},
        '{FUNC_RELEASE, 8'd1,   8'd0,   1'b0, '{REPLY_OK,     NOTE_NONE,   8'd0,   1'b0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] lock_index, [15:8] client_id
    logic        s_axis_tuser;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [1:0] reply_code, [9:2] notify_client, [10] queue_overflow
    logic [1:0]  m_axis_tuser;   // notify_kind

    // shadow lock table
    logic                lock_held   [NUM_LOCKS];
    logic [CLIENT_W-1:0] lock_owner  [NUM_LOCKS];
    logic [CLIENT_W-1:0] waiter_slot [NUM_LOCKS][QUEUE_DEPTH];
    logic [QPTR_W-1:0]   q_head      [NUM_LOCKS];
    logic [QCNT_W-1:0]   q_count     [NUM_LOCKS];

    t_result pending_results [$];
    int      mismatches  = 0;
    int      cycle_count = 0;
    logic    calm        = 1'b0;

    caching_lock_manager uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // applies one request to the shadow table and returns its answer
    function automatic t_result resolve_request(input logic fn, input logic [LOCK_W-1:0] lk,
                                                input logic [CLIENT_W-1:0] cl);
        t_result           r;
        logic [QPTR_W-1:0] slot;
        r = '{REPLY_OK, NOTE_NONE, '0, 1'b0};
        if (fn == FUNC_ACQUIRE) begin
            if (lock_held[lk]) begin
                if (lock_owner[lk] != cl) begin
                    r.reply = REPLY_RETRY;
                    if (q_count[lk] == QCNT_W'(QUEUE_DEPTH)) begin
                        r.ovf = 1'b1;
                    end else begin
                        slot = q_head[lk] + q_count[lk][QPTR_W-1:0];
                        waiter_slot[lk][slot] = cl;
                        // first waiter triggers a revoke to the holder
                        if (q_count[lk] == '0) begin
                            r.kind   = NOTE_REVOKE;
                            r.target = lock_owner[lk];
                        end
                        q_count[lk] = q_count[lk] + 1'b1;
                    end
                end else if (q_count[lk] != '0) begin
                    r.reply = REPLY_RETIRE;
                end
            end else if (q_count[lk] == '0) begin
                lock_held[lk]  = 1'b1;
                lock_owner[lk] = cl;
            end
        end else if (lock_held[lk] && lock_owner[lk] == cl) begin
            // holder lets go: hand over to the head waiter, or free the lock
            if (q_count[lk] != '0) begin
                lock_owner[lk] = waiter_slot[lk][q_head[lk]];
                q_head[lk]     = q_head[lk] + 1'b1;
                q_count[lk]    = q_count[lk] - 1'b1;
                r.kind         = NOTE_RETRY;
                r.target       = lock_owner[lk];
            end else begin
                lock_held[lk] = 1'b0;
            end
        end
        return r;
    endfunction

    // presents one request, waits for acceptance, records its answer
    task automatic issue(input t_req_row row);
        t_result answer;
        while (!calm && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.fn;
        s_axis_tdata  <= {row.cl, row.lk};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        answer = resolve_request(row.fn, row.lk, row.cl);
        pending_results.insert(pending_results.size(), row.typed ? row.res : answer);
    endtask

    // hold the sender back until every answer is in
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // result side: random back-pressure and checking
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n !== 1'b1) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || $urandom_range(99) >= 16;
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[1:0], m_axis_tuser, m_axis_tdata[9:2], m_axis_tdata[10]};
                if (pending_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result word: reply %0d kind %0d target %0d ovf %0d",
                                 got.reply, got.kind, got.target, got.ovf);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"mismatch: exp reply %0d kind %0d target %0d ovf %0d,",
                                      " got reply %0d kind %0d target %0d ovf %0d"},
                                     want.reply, want.kind, want.target, want.ovf,
                                     got.reply, got.kind, got.target, got.ovf);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_req_row            row;
        logic [LOCK_W-1:0]   hot_lock [4];
        logic [CLIENT_W-1:0] crowd    [10];
        int                  r;
        int                  release_share;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_ACQUIRE;
        for (int i = 0; i < NUM_LOCKS; i++) begin
            lock_held[i] = 1'b0;
            q_head[i]    = '0;
            q_count[i]   = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sequence
        for (int i = 0; i < DIRECTED_ROWS; i++) issue(PLAN[i]);
        drain();

        // random traffic on a few busy locks, shared by a small crowd of clients
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0) begin
                foreach (hot_lock[k]) hot_lock[k] = LOCK_W'($urandom_range(NUM_LOCKS - 1));
                foreach (crowd[k]) crowd[k] = CLIENT_W'($urandom_range(255));
            end
            if (n == 600) drain();
            calm          = (n >= 300 && n < 450);
            release_share = ((n / 100) % 2) ? 15 : 40;
            r             = $urandom_range(99);
            row           = '0;
            row.fn        = FUNC_ACQUIRE;
            row.lk        = hot_lock[$urandom_range(3)];
            row.cl        = crowd[$urandom_range(9)];
            if (r < 10) begin
                // noise over the whole field range
                row.fn = 1'($urandom_range(1));
                row.lk = LOCK_W'($urandom_range(NUM_LOCKS - 1));
                row.cl = CLIENT_W'($urandom_range(255));
            end else if (lock_held[row.lk] && r < 10 + release_share) begin
                row.fn = FUNC_RELEASE;
                row.cl = lock_owner[row.lk];
            end else if (lock_held[row.lk] && r < 20 + release_share) begin
                row.cl = lock_owner[row.lk];
            end else if (r >= 92) begin
                row.fn = FUNC_RELEASE;
            end
            issue(row);
        end
        calm = 1'b0;
        drain();
        repeat (12) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/clm_pkg.sv
rtl/core/clm_ram.sv
rtl/core/clm_update.sv
rtl/core/caching_lock_manager.sv
verif/tb_caching_lock_manager.sv
